// ===== sv/sgpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled glyph pixel generator package
// Shared types, constants and the 5x7 font table.
// ----------------------------------------------------------------------------
package sgpg_pkg;

  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;

  localparam logic [7:0] FONT_W_SCALE2 = 8'd10;
  localparam logic [7:0] FONT_W_SCALE3 = 8'd18;
  localparam logic [7:0] FONT_H_SCALE2 = 8'd16;
  localparam logic [7:0] FONT_H_SCALE3 = 8'd24;

  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
  localparam logic [4:0] LAST_ROW = 5'(GLYPH_ROWS - 1);

  typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] glyph_t;

  typedef enum logic [1:0] {
    REG_ORIENTATION = 2'd0,
    REG_FONT_WIDTH  = 2'd1,
    REG_FONT_HEIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NEXT,
    ST_ADDX,
    ST_ADDY,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       found;
    logic [2:0] col;
  } scan_res_t;

  function automatic glyph_t glyph_pack(logic [4:0] r0, logic [4:0] r1, logic [4:0] r2,
                                        logic [4:0] r3, logic [4:0] r4, logic [4:0] r5,
                                        logic [4:0] r6);
    glyph_t g;
    g[0] = r0;
    g[1] = r1;
    g[2] = r2;
    g[3] = r3;
    g[4] = r4;
    g[5] = r5;
    g[6] = r6;
    return g;
  endfunction

  // Lower case folds to upper case; codes without a glyph get the question mark.
  function automatic glyph_t glyph_lookup(logic [7:0] code);
    logic [7:0] c;
    glyph_t     g;
    c = code;
    if (code >= "a" && code <= "z") begin
      c = code - 8'd32;
    end
    case (c)
      " ": g = glyph_pack(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00);
      "+": g = glyph_pack(5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00);
      "-": g = glyph_pack(5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00);
      ".": g = glyph_pack(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C);
      ":": g = glyph_pack(5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00);
      "/": g = glyph_pack(5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00);
      "0": g = glyph_pack(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E);
      "1": g = glyph_pack(5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
      "2": g = glyph_pack(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F);
      "3": g = glyph_pack(5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E);
      "4": g = glyph_pack(5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02);
      "5": g = glyph_pack(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E);
      "6": g = glyph_pack(5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E);
      "7": g = glyph_pack(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08);
      "8": g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E);
      "9": g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E);
      "A": g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
      "B": g = glyph_pack(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E);
      "C": g = glyph_pack(5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E);
      "D": g = glyph_pack(5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E);
      "E": g = glyph_pack(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F);
      "F": g = glyph_pack(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10);
      "G": g = glyph_pack(5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E);
      "H": g = glyph_pack(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
      "I": g = glyph_pack(5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
      "J": g = glyph_pack(5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C);
      "K": g = glyph_pack(5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11);
      "L": g = glyph_pack(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F);
      "M": g = glyph_pack(5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11);
      "N": g = glyph_pack(5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11);
      "O": g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
      "P": g = glyph_pack(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10);
      "Q": g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D);
      "R": g = glyph_pack(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11);
      "S": g = glyph_pack(5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E);
      "T": g = glyph_pack(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
      "U": g = glyph_pack(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
      "V": g = glyph_pack(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04);
      "W": g = glyph_pack(5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A);
      "X": g = glyph_pack(5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11);
      "Y": g = glyph_pack(5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04);
      "Z": g = glyph_pack(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F);
      default: g = glyph_pack(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04);
    endcase
    return g;
  endfunction

  function automatic logic [1:0] scale_sel(logic [7:0] size, logic [7:0] thr2,
                                           logic [7:0] thr3);
    logic [1:0] s;
    s = 2'd1;
    if (size >= thr3) begin
      s = 2'd3;
    end else if (size >= thr2) begin
      s = 2'd2;
    end
    return s;
  endfunction

endpackage

// ===== sv/sgpg_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph row scanner
// Finds the leftmost set bit of one glyph row at or after a start column.
// ----------------------------------------------------------------------------
module sgpg_scan (
  input  logic [sgpg_pkg::GLYPH_COLS-1:0] row_bits_i,
  input  logic [2:0]                      start_col_i,
  output sgpg_pkg::scan_res_t             res_o
);

  always_comb begin
    res_o = '0;
    for (int c = sgpg_pkg::GLYPH_COLS - 1; c >= 0; c--) begin
      if (row_bits_i[sgpg_pkg::GLYPH_COLS-1-c] && (3'(c) >= start_col_i)) begin
        res_o.found = 1'b1;
        res_o.col   = 3'(c);
      end
    end
  end

endmodule

// ===== sv/sgpg_addcmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate add and bound compare
// Adds a box offset to a 16-bit base and checks the sum against a panel bound.
// ----------------------------------------------------------------------------
module sgpg_addcmp (
  input  logic [15:0] base_i,
  input  logic [4:0]  offset_i,
  input  logic [15:0] limit_i,
  output logic [15:0] sum_o,
  output logic        below_o
);

  assign sum_o   = base_i + 16'(offset_i);
  assign below_o = sum_o < limit_i;

endmodule

// ===== sv/scaled_glyph_pixel_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled glyph pixel generator
// Turns one 5x7 font character into a stream of pixel writes, one per step.
// ----------------------------------------------------------------------------
// A background step passes through the X add, the Y add and the output state;
// a foreground step adds one to seven row scans to find its glyph cell
// and, at the end of a scale block, up to seven more to find the next one.
// One row of glyph bits is scanned per cycle and one coordinate is added and
// bounded per cycle. Reset clears all control state; there is no clearing pass.
module scaled_glyph_pixel_generator #(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], origin_x[23:8], origin_y[39:24], fg_color[55:40], bg_color[71:56]
  input  logic [71:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x[15:0], pixel_y[31:16], pixel_color[47:32]
  output logic [47:0] m_axis_tdata,
  // pixel_present[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  sgpg_pkg::state_e    state_q, state_d;
  logic                busy_q, busy_d;
  logic                fill_q, fill_d;
  logic [4:0]          row_q, row_d;
  logic [3:0]          col_q, col_d;
  logic [1:0]          sub_row_q, sub_row_d;
  logic [1:0]          sub_col_q, sub_col_d;
  logic [1:0]          sx_q, sx_d;
  logic [1:0]          sy_q, sy_d;
  logic [1:0]          orient_q;
  logic [7:0]          font_w_q;
  logic [7:0]          font_h_q;
  logic                out_valid_q;

  sgpg_pkg::glyph_t    glyph_q, glyph_d;
  logic [15:0]         base_x_q, base_x_d;
  logic [15:0]         base_y_q, base_y_d;
  logic [15:0]         fg_q, fg_d;
  logic [15:0]         bg_q, bg_d;
  logic [3:0]          dx_q, dx_d;
  logic [4:0]          dy_q, dy_d;
  logic [15:0]         color_q, color_d;
  logic                last_q, last_d;
  logic [15:0]         px_q, px_d;
  logic [15:0]         py_q, py_d;
  logic                pres_q, pres_d;
  logic [15:0]         out_x_q, out_y_q, out_color_q;
  logic                out_pres_q, out_last_q;

  logic                in_acc;
  logic                out_load;
  logic [3:0]          fill_w;
  logic [4:0]          fill_h;
  logic [4:0]          scan_bits;
  sgpg_pkg::scan_res_t scan_res;
  logic [15:0]         au_base, au_sum, au_limit;
  logic [4:0]          au_off;
  logic                au_below;
  logic [15:0]         panel_w, panel_h;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == sgpg_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign fill_w  = 4'(sx_q) * 4'(sgpg_pkg::GLYPH_COLS);
  assign fill_h  = 5'(sy_q) * 5'(sgpg_pkg::GLYPH_ROWS);
  assign panel_w = orient_q[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
  assign panel_h = orient_q[0] ? 16'(PANEL_WIDTH) : 16'(PANEL_HEIGHT);

  assign scan_bits = (row_q <= sgpg_pkg::LAST_ROW) ? glyph_q[row_q[2:0]] : '0;

  sgpg_scan u_scan (
    .row_bits_i  (scan_bits),
    .start_col_i (col_q[2:0]),
    .res_o       (scan_res)
  );

  assign au_base  = (state_q == sgpg_pkg::ST_ADDY) ? base_y_q : base_x_q;
  assign au_off   = (state_q == sgpg_pkg::ST_ADDY) ? dy_q : {1'b0, dx_q};
  assign au_limit = (state_q == sgpg_pkg::ST_ADDY) ? panel_h : panel_w;

  sgpg_addcmp u_addcmp (
    .base_i   (au_base),
    .offset_i (au_off),
    .limit_i  (au_limit),
    .sum_o    (au_sum),
    .below_o  (au_below)
  );

  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    fill_d    = fill_q;
    row_d     = row_q;
    col_d     = col_q;
    sub_row_d = sub_row_q;
    sub_col_d = sub_col_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    glyph_d   = glyph_q;
    base_x_d  = base_x_q;
    base_y_d  = base_y_q;
    fg_d      = fg_q;
    bg_d      = bg_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    color_d   = color_q;
    last_d    = last_q;
    px_d      = px_q;
    py_d      = py_q;
    pres_d    = pres_q;
    out_load  = 1'b0;
    unique case (state_q)
      sgpg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == sgpg_pkg::CMD_START) begin
            glyph_d   = sgpg_pkg::glyph_lookup(s_axis_tdata[7:0]);
            base_x_d  = s_axis_tdata[23:8];
            base_y_d  = s_axis_tdata[39:24];
            fg_d      = s_axis_tdata[55:40];
            bg_d      = s_axis_tdata[71:56];
            sx_d      = sgpg_pkg::scale_sel(font_w_q, sgpg_pkg::FONT_W_SCALE2,
                                            sgpg_pkg::FONT_W_SCALE3);
            sy_d      = sgpg_pkg::scale_sel(font_h_q, sgpg_pkg::FONT_H_SCALE2,
                                            sgpg_pkg::FONT_H_SCALE3);
            fill_d    = s_axis_tdata[55:40] != s_axis_tdata[71:56];
            row_d     = '0;
            col_d     = '0;
            sub_row_d = '0;
            sub_col_d = '0;
            busy_d    = 1'b1;
          end else if (busy_q) begin
            if (fill_q) begin
              dx_d    = col_q;
              dy_d    = row_q;
              color_d = bg_q;
              last_d  = 1'b0;
              if (col_q == fill_w - 4'd1) begin
                col_d = '0;
                row_d = row_q + 5'd1;
                if (row_q == fill_h - 5'd1) begin
                  fill_d = 1'b0;
                  row_d  = '0;
                  if (glyph_q == '0) begin
                    last_d = 1'b1;
                    busy_d = 1'b0;
                  end
                end
              end else begin
                col_d = col_q + 4'd1;
              end
              state_d = sgpg_pkg::ST_ADDX;
            end else begin
              state_d = sgpg_pkg::ST_SCAN;
            end
          end
        end
      end
      sgpg_pkg::ST_SCAN: begin
        if (scan_res.found) begin
          dx_d    = 4'(scan_res.col) * 4'(sx_q) + 4'(sub_col_q);
          dy_d    = 5'(row_q[2:0]) * 5'(sy_q) + 5'(sub_row_q);
          color_d = fg_q;
          last_d  = 1'b0;
          col_d   = 4'(scan_res.col);
          if (sub_col_q == sx_q - 2'd1) begin
            sub_col_d = '0;
            if (sub_row_q == sy_q - 2'd1) begin
              sub_row_d = '0;
              if (scan_res.col == sgpg_pkg::LAST_COL) begin
                col_d = '0;
                row_d = row_q + 5'd1;
              end else begin
                col_d = 4'(scan_res.col) + 4'd1;
              end
              state_d = sgpg_pkg::ST_NEXT;
            end else begin
              sub_row_d = sub_row_q + 2'd1;
              state_d   = sgpg_pkg::ST_ADDX;
            end
          end else begin
            sub_col_d = sub_col_q + 2'd1;
            state_d   = sgpg_pkg::ST_ADDX;
          end
        end else if (row_q >= sgpg_pkg::LAST_ROW) begin
          busy_d  = 1'b0;
          px_d    = '0;
          py_d    = '0;
          pres_d  = 1'b0;
          color_d = '0;
          last_d  = 1'b1;
          state_d = sgpg_pkg::ST_OUT;
        end else begin
          row_d = row_q + 5'd1;
          col_d = '0;
        end
      end
      sgpg_pkg::ST_NEXT: begin
        if (scan_res.found) begin
          col_d   = 4'(scan_res.col);
          state_d = sgpg_pkg::ST_ADDX;
        end else if (row_q >= sgpg_pkg::LAST_ROW) begin
          last_d  = 1'b1;
          busy_d  = 1'b0;
          row_d   = '0;
          col_d   = '0;
          state_d = sgpg_pkg::ST_ADDX;
        end else begin
          row_d = row_q + 5'd1;
          col_d = '0;
        end
      end
      sgpg_pkg::ST_ADDX: begin
        px_d    = au_sum;
        pres_d  = au_below;
        state_d = sgpg_pkg::ST_ADDY;
      end
      sgpg_pkg::ST_ADDY: begin
        py_d    = au_sum;
        pres_d  = pres_q && au_below;
        state_d = sgpg_pkg::ST_OUT;
      end
      sgpg_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = sgpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sgpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sgpg_pkg::ST_IDLE;
      busy_q    <= 1'b0;
      fill_q    <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      sub_row_q <= '0;
      sub_col_q <= '0;
      sx_q      <= 2'd1;
      sy_q      <= 2'd1;
    end else begin
      state_q   <= state_d;
      busy_q    <= busy_d;
      fill_q    <= fill_d;
      row_q     <= row_d;
      col_q     <= col_d;
      sub_row_q <= sub_row_d;
      sub_col_q <= sub_col_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= '0;
      font_w_q <= '0;
      font_h_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        sgpg_pkg::REG_ORIENTATION: orient_q <= cfg_data_i[1:0];
        sgpg_pkg::REG_FONT_WIDTH:  font_w_q <= cfg_data_i;
        sgpg_pkg::REG_FONT_HEIGHT: font_h_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q  <= glyph_d;
    base_x_q <= base_x_d;
    base_y_q <= base_y_d;
    fg_q     <= fg_d;
    bg_q     <= bg_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    color_q  <= color_d;
    last_q   <= last_d;
    px_q     <= px_d;
    py_q     <= py_d;
    pres_q   <= pres_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q     <= px_q;
      out_y_q     <= py_q;
      out_color_q <= color_q;
      out_pres_q  <= pres_q;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_color_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_pres_q;
  assign m_axis_tlast  = out_last_q;

  a_fill_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q |-> busy_q)
    else $error("Background fill active while the generator is idle.");

  a_cursor_in_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !fill_q) |-> (row_q <= 5'(sgpg_pkg::GLYPH_ROWS)))
    else $error("Glyph cursor ran past the glyph rows.");

  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sx_q != 2'd0) && (sy_q != 2'd0))
    else $error("Latched scale is zero.");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sgpg_pkg::ST_OUT))
    else $error("Result register loaded outside the output state.");

endmodule
